### rtl/core/cfbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cfbd_pkg;

  localparam int KEY_WORDS = 30;
  localparam int KEY_ROWS = KEY_WORDS / 2;
  localparam int ROW_W = $clog2(KEY_ROWS);
  localparam logic [3:0] MIN_ROUNDS = 4'd10;
  localparam logic [3:0] MAX_ROUNDS = 4'(KEY_ROWS - 1);
  localparam logic [3:0] RESET_ROUNDS = 4'd10;
  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [1:0] {
    KIND_LOAD_KEY = 2'd0,
    KIND_LOAD_FB = 2'd1,
    KIND_BLOCK = 2'd2,
    KIND_BYTE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN = 2'd1,
    ST_FIN = 2'd2
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             wr_half;
    logic [63:0]      wr_data;
    logic [ROW_W-1:0] rd_row;
  } key_req_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

### rtl/core/cfbd_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cfbd_key_ram (
  input  wire logic              clk,
  input  wire cfbd_pkg::key_req_t req,
  output logic [127:0]           rd_key
);
  import cfbd_pkg::*;

  logic [63:0] lo_mem [KEY_ROWS];
  logic [63:0] hi_mem [KEY_ROWS];
  logic [63:0] lo_q_r;
  logic [63:0] hi_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en && !req.wr_half) begin
      lo_mem[req.wr_row] <= req.wr_data;
    end
    if (req.wr_en && req.wr_half) begin
      hi_mem[req.wr_row] <= req.wr_data;
    end
    lo_q_r <= lo_mem[req.rd_row];
    hi_q_r <= hi_mem[req.rd_row];
  end

  assign rd_key = {hi_q_r, lo_q_r};
endmodule
`default_nettype wire

### rtl/core/cfbd_round.sv
`timescale 1ns / 1ps
`default_nettype none
module cfbd_round (
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] round_key,
  input  wire logic         mix_en,
  output logic [127:0]      state_out
);
  import cfbd_pkg::*;

  logic [127:0] shifted;
  logic [127:0] mixed;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[8*(r+4*c) +: 8] = SBOX[state_in[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = shifted[32*c +: 8];
      a1 = shifted[32*c+8 +: 8];
      a2 = shifted[32*c+16 +: 8];
      a3 = shifted[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[32*c +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      mixed[32*c+8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      mixed[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      mixed[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
  end

  assign state_out = (mix_en ? mixed : shifted) ^ round_key;
endmodule
`default_nettype wire

### rtl/core/aes_cfb128_decrypt_core.sv
// AES-CFB128 decryption core.
// The input channel (in_) carries one transaction per item: in_tuser holds the kind
// (load round-key word, load feedback half, decrypt block, decrypt byte), in_tdata the
// word index and the two 64-bit data halves. The output channel (out_) carries one
// plaintext transaction for each decrypt item; loads produce none.
// Round keys live in a synchronous memory with a registered read, one 128-bit row per round.
// A block item, and a byte item at byte position 0, run the iterative round engine:
// the initial key addition, then each round in turn, then a finishing step that
// waits for the output register to be free before the result appears; the engine
// takes no new item until it is back in idle. Byte items at other positions and
// loads are handled in idle without the engine.
// A result waits in the output register while the receiver stalls; loads, new block
// items and byte items at byte position 0 are still accepted then, but a finished
// encryption is held in the engine until the output register frees.
// cfg_wr_en writes round_count; write it only while the core is idle.
// Reset (rst_n low, synchronous) clears feedback, keystream, byte position and sets
// round_count to 10; the key memory is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module aes_cfb128_decrypt_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [3:0]                     cfg_wr_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // word_index[4:0], in_high[68:5], in_low[132:69], zero[135:133]
  input  wire logic [cfbd_pkg::IN_DATA_W-1:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // plain_high[63:0], plain_low[127:64]
  output logic [cfbd_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import cfbd_pkg::*;

  state_t        st_r, st_nxt;
  logic [3:0]    rc_r, rc_nxt;
  logic [3:0]    rnd_r, rnd_nxt;
  logic [127:0]  fb_r, fb_nxt;
  logic [127:0]  ks_r, ks_nxt;
  logic [3:0]    pos_r, pos_nxt;
  logic          is_byte_r, is_byte_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [127:0]  aes_r, aes_nxt;
  logic [127:0]  item_r, item_nxt;
  logic [127:0]  out_data_r, out_data_nxt;

  kind_t         kind;
  logic [4:0]    word_index;
  logic [63:0]   data_hi;
  logic [63:0]   data_lo;
  logic          accept;
  logic          out_free;
  logic [3:0]    nr;
  logic [127:0]  key;
  logic [127:0]  round_out;
  key_req_t      key_req;
  logic [127:0]  bs_ks;
  logic [3:0]    bs_pos;
  logic [7:0]    bs_in;
  logic [7:0]    bs_pt;
  logic [127:0]  bs_ks_upd;

  assign kind = kind_t'(in_tuser);
  assign word_index = in_tdata[4:0];
  assign data_hi = in_tdata[68:5];
  assign data_lo = in_tdata[132:69];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && (kind != KIND_BYTE || pos_r == 4'd0 || out_free);
  assign accept = in_tvalid && in_tready;
  assign nr = (rc_r < MIN_ROUNDS) ? MIN_ROUNDS : ((rc_r > MAX_ROUNDS) ? MAX_ROUNDS : rc_r);

  always_comb begin
    key_req.wr_en = accept && kind == KIND_LOAD_KEY && word_index < 5'(KEY_WORDS);
    key_req.wr_row = word_index[ROW_W:1];
    key_req.wr_half = word_index[0];
    key_req.wr_data = data_lo;
    key_req.rd_row = (st_r == ST_RUN && rnd_r != nr) ? ROW_W'(rnd_r + 4'd1) : '0;
  end

  cfbd_key_ram u_key_ram (
    .clk    (clk),
    .req    (key_req),
    .rd_key (key)
  );

  cfbd_round u_round (
    .state_in  (aes_r),
    .round_key (key),
    .mix_en    (rnd_r != nr),
    .state_out (round_out)
  );

  always_comb begin
    bs_ks = (st_r == ST_FIN) ? aes_r : ks_r;
    bs_pos = (st_r == ST_FIN) ? 4'd0 : pos_r;
    bs_in = (st_r == ST_FIN) ? item_r[7:0] : data_lo[7:0];
    bs_pt = bs_ks[8*bs_pos +: 8] ^ bs_in;
    bs_ks_upd = bs_ks;
    bs_ks_upd[8*bs_pos +: 8] = bs_in;
  end

  always_comb begin
    st_nxt = st_r;
    rc_nxt = cfg_wr_en ? cfg_wr_data : rc_r;
    rnd_nxt = rnd_r;
    fb_nxt = fb_r;
    ks_nxt = ks_r;
    pos_nxt = pos_r;
    is_byte_nxt = is_byte_r;
    out_valid_nxt = out_valid_r && !out_tready;
    aes_nxt = aes_r;
    item_nxt = item_r;
    out_data_nxt = out_data_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD_KEY: begin
            end
            KIND_LOAD_FB: begin
              if (word_index == 5'd0) begin
                fb_nxt[63:0] = data_lo;
              end else if (word_index == 5'd1) begin
                fb_nxt[127:64] = data_lo;
              end
            end
            KIND_BLOCK: begin
              item_nxt = {data_hi, data_lo};
              is_byte_nxt = 1'b0;
              rnd_nxt = 4'd0;
              st_nxt = ST_RUN;
            end
            default: begin
              if (pos_r == 4'd0) begin
                item_nxt = {data_hi, data_lo};
                is_byte_nxt = 1'b1;
                rnd_nxt = 4'd0;
                st_nxt = ST_RUN;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt = {56'd0, bs_pt, 64'd0};
                ks_nxt = bs_ks_upd;
                pos_nxt = pos_r + 4'd1;
                if (pos_r == 4'd15) begin
                  fb_nxt = bs_ks_upd;
                end
              end
            end
          endcase
        end
      end
      ST_RUN: begin
        aes_nxt = (rnd_r == 4'd0) ? (fb_r ^ key) : round_out;
        if (rnd_r == nr) begin
          st_nxt = ST_FIN;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt = ST_IDLE;
          if (is_byte_r) begin
            out_data_nxt = {56'd0, bs_pt, 64'd0};
            ks_nxt = bs_ks_upd;
            pos_nxt = 4'd1;
          end else begin
            out_data_nxt = {item_r[63:0] ^ aes_r[63:0], item_r[127:64] ^ aes_r[127:64]};
            fb_nxt = item_r;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rc_r <= RESET_ROUNDS;
      rnd_r <= 4'd0;
      fb_r <= '0;
      ks_r <= '0;
      pos_r <= 4'd0;
      is_byte_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rc_r <= rc_nxt;
      rnd_r <= rnd_nxt;
      fb_r <= fb_nxt;
      ks_r <= ks_nxt;
      pos_r <= pos_nxt;
      is_byte_r <= is_byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    aes_r <= aes_nxt;
    item_r <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule
`default_nettype wire

### rtl/core/cfbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cfbd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);
  import cfbd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid &&
     (in_tuser == KIND_LOAD_KEY || in_tuser == KIND_LOAD_FB)) |=> !out_tvalid)
    else $error("A load transaction produced a result.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("Output valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("Output data changed while stalled.");
endmodule

bind aes_cfb128_decrypt_core cfbd_checker u_cfbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
